@@ src/frl_pkg.sv @@
// Shared types and constants for the flood control rate limiter.
// No dependencies.
`timescale 1ns / 1ps

package frl_pkg;

   localparam int FRL_QUEUE_DEPTH = 16;
   localparam int TIME_W          = 32;
   localparam int TAG_W           = 16;
   localparam int CSR_DATA_W      = 8;
   localparam int CSR_INDEX_W     = 1;
   localparam int MAX_DRAIN       = 16;
   localparam int DRAIN_CNT_W     = $clog2(MAX_DRAIN);

   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_INTERVAL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LIMIT   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RST_SEND_INTERVAL = 8'd2;
   localparam logic [CSR_DATA_W-1:0] RST_BURST_LIMIT   = 8'd10;

   typedef enum logic {
      OP_MESSAGE = 1'b0,
      OP_TICK    = 1'b1
   } frl_op_type;

   typedef enum logic [1:0] {
      ACT_SENT       = 2'd0,
      ACT_QUEUED     = 2'd1,
      ACT_DROPPED    = 2'd2,
      ACT_FROM_QUEUE = 2'd3
   } frl_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DRAIN
   } frl_state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } frl_queue_cmd_type;

   typedef struct packed {
      logic empty;
      logic one_left;
      logic full;
   } frl_queue_sts_type;

endpackage

@@ src/frl_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module frl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/frl_queue.sv @@
// Held-tag FIFO: pointers and fill count around one frl_ram; uses frl_pkg and frl_ram.
// Read data is the read-pointer entry, stale just after a push into an empty queue.
`timescale 1ns / 1ps

module frl_queue import frl_pkg::*; #(
   parameter int QUEUE_DEPTH = FRL_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  frl_queue_cmd_type cmd,
   input  logic [TAG_W-1:0]  push_data,
   output logic [TAG_W-1:0]  rd_data,
   output frl_queue_sts_type sts
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_ONE;
      end
      if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.one_left = (count_ff == CNT_ONE);
   assign sts.full     = (count_ff == CNT_FULL);

   // read address runs one step ahead so data matches rd_ptr_ff
   frl_ram #(
      .WIDTH (TAG_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_in),
      .rd_data (rd_data)
   );

endmodule

@@ src/flood_control_rate_limiter.sv @@
// Pass-through message: result registered after the transfer; limited message: result from the decide state.
// Pass-through takes 1 item/cycle while the block is not busy; a limited message holds busy through the decide state.
// Tick: drained tags come from the drain state after the idle state, 1/cycle (one queue read per cycle),
// up to 16 tags; busy while in the drain state, which is entered even when no tag drains. Results cannot be stalled.
// Reset: next-send time and queue cleared, send_interval = 2, burst_limit = 10;
// queue storage is not cleared.
`timescale 1ns / 1ps

module flood_control_rate_limiter import frl_pkg::*; #(
   parameter int QUEUE_DEPTH = FRL_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [TIME_W-1:0]      req_now_seconds,
   input  logic [TAG_W-1:0]       req_message_tag,
   input  logic                   req_to_server,
   input  logic                   req_is_tcp_link,
   output logic                   rsp_valid,
   output logic [TAG_W-1:0]       rsp_out_tag,
   output logic [1:0]             rsp_action,
   output logic                   rsp_last_of_run,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam logic [DRAIN_CNT_W-1:0] DRAIN_LAST = DRAIN_CNT_W'(MAX_DRAIN - 1);

   frl_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0]  send_interval_ff, send_interval_in;
   logic [CSR_DATA_W-1:0]  burst_limit_ff, burst_limit_in;
   logic [TIME_W-1:0]      nst_ff, nst_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [DRAIN_CNT_W-1:0] drain_cnt_ff, drain_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   frl_action_type         rsp_action_ff, rsp_action_in;
   logic                   rsp_last_ff, rsp_last_in;

   frl_queue_cmd_type q_cmd;
   frl_queue_sts_type q_sts;
   logic [TAG_W-1:0]  q_rd_data;

   logic              accept;
   logic              limited;
   logic [TIME_W-1:0] nst_raised;
   logic [TIME_W:0]   adv_sum;
   logic [TIME_W-1:0] nst_adv;
   logic [TIME_W-1:0] lead;
   logic              over;
   logic              can_drain;
   logic              more;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = req_start && !busy;
   assign limited = req_to_server && req_is_tcp_link;

   assign nst_raised = (nst_ff < req_now_seconds) ? req_now_seconds : nst_ff;
   assign adv_sum    = {1'b0, nst_ff} + {{(TIME_W + 1 - CSR_DATA_W){1'b0}}, send_interval_ff};
   assign nst_adv    = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];
   assign lead       = nst_ff - now_ff;
   assign over       = lead > {{(TIME_W - CSR_DATA_W){1'b0}}, burst_limit_ff};
   assign can_drain  = !q_sts.empty && (nst_ff <= now_ff);
   assign more       = (drain_cnt_ff != DRAIN_LAST) && !q_sts.one_left && (nst_adv <= now_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_TICK) begin
                  state_in = ST_DRAIN;
               end else if (limited) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (!(can_drain && more)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      nst_in        = nst_ff;
      now_in        = now_ff;
      tag_in        = tag_ff;
      drain_cnt_in  = drain_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_tag_in    = rsp_tag_ff;
      rsp_action_in = rsp_action_ff;
      rsp_last_in   = 1'b1;
      q_cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in       = req_now_seconds;
               tag_in       = req_message_tag;
               drain_cnt_in = '0;
               if (req_operation == OP_TICK || limited) begin
                  nst_in = nst_raised;
               end
               if (req_operation == OP_MESSAGE && !limited) begin
                  rsp_valid_in  = 1'b1;
                  rsp_tag_in    = req_message_tag;
                  rsp_action_in = ACT_SENT;
               end
            end
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_tag_in   = tag_ff;
            if (over) begin
               if (q_sts.full) begin
                  rsp_action_in = ACT_DROPPED;
               end else begin
                  rsp_action_in = ACT_QUEUED;
                  q_cmd.push    = 1'b1;
               end
            end else begin
               rsp_action_in = ACT_SENT;
               nst_in        = nst_adv;
            end
         end
         ST_DRAIN: begin
            if (can_drain) begin
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = q_rd_data;
               rsp_action_in = ACT_FROM_QUEUE;
               rsp_last_in   = !more;
               q_cmd.pop     = 1'b1;
               nst_in        = nst_adv;
               drain_cnt_in  = drain_cnt_ff + DRAIN_CNT_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      send_interval_in = send_interval_ff;
      burst_limit_in   = burst_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SEND_INTERVAL: send_interval_in = csr_wr_data;
            CSR_BURST_LIMIT:   burst_limit_in   = csr_wr_data;
            default:           send_interval_in = send_interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         send_interval_ff <= RST_SEND_INTERVAL;
         burst_limit_ff   <= RST_BURST_LIMIT;
         nst_ff           <= '0;
         drain_cnt_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         send_interval_ff <= send_interval_in;
         burst_limit_ff   <= burst_limit_in;
         nst_ff           <= nst_in;
         drain_cnt_ff     <= drain_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      tag_ff        <= tag_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_action_ff <= rsp_action_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // queue writes only in decide; a tick reads after the idle cycle, so no forwarding
   frl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .push_data (tag_ff),
      .rd_data   (q_rd_data),
      .sts       (q_sts)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_decide_gives_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |=> rsp_valid_ff)
      else $error("decide stage gave no result");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_cmd.push |-> !q_sts.full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_cmd.pop |-> !q_sts.empty)
      else $error("pop from empty queue");

   a_drain_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && drain_cnt_ff == DRAIN_LAST |=> state_ff == ST_IDLE)
      else $error("drain exceeded per-tick cap");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && rsp_valid_in && rsp_last_in |=> !busy)
      else $error("drain continued after last result");

endmodule

@@ verif/frl_outcome_checker.sv @@
// Response checker for the flood control rate limiter: mirrors the next-send time and
// the held-tag backlog, predicts every response and compares it field by field.
// Depends on frl_pkg.
`timescale 1ns / 1ps

module frl_outcome_checker import frl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   input  logic                   busy,
   input  logic                   req_operation,
   input  logic [TIME_W-1:0]      req_now_seconds,
   input  logic [TAG_W-1:0]       req_message_tag,
   input  logic                   req_to_server,
   input  logic                   req_is_tcp_link,
   input  logic                   rsp_valid,
   input  logic [TAG_W-1:0]       rsp_out_tag,
   input  logic [1:0]             rsp_action,
   input  logic                   rsp_last_of_run,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     mismatches,
   output int                     outstanding,
   output int                     checked
);

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      frl_action_type   act;
      logic             last;
   } outcome_type;

   outcome_type           expected_outcomes[$];
   logic [TAG_W-1:0]      held_backlog[$];
   logic [CSR_DATA_W-1:0] interval_cfg = RST_SEND_INTERVAL;
   logic [CSR_DATA_W-1:0] burst_cfg    = RST_BURST_LIMIT;
   logic [TIME_W-1:0]     send_at      = '0;
   int                    errors       = 0;
   int                    compared     = 0;
   int                    pending      = 0;

   assign mismatches  = errors;
   assign outstanding = pending;
   assign checked     = compared;

   // saturating advance of the next-send time
   function automatic void advance_send_at();
      logic [TIME_W-1:0] room;
      room = '1 - send_at;
      if (TIME_W'(interval_cfg) > room) begin
         send_at = '1;
      end else begin
         send_at = send_at + TIME_W'(interval_cfg);
      end
   endfunction

   function automatic void predict_outcomes(input logic op, input logic [TIME_W-1:0] now,
                                            input logic [TAG_W-1:0] tag, input logic srv,
                                            input logic tcp);
      outcome_type o;
      int          drained;
      drained = 0;
      if (op == OP_MESSAGE) begin
         o.tag  = tag;
         o.last = 1'b1;
         if (!srv || !tcp) begin
            o.act = ACT_SENT;
         end else begin
            if (send_at < now) send_at = now;
            if (send_at - now > TIME_W'(burst_cfg)) begin
               if (held_backlog.size() < FRL_QUEUE_DEPTH) begin
                  held_backlog.push_back(tag);
                  o.act = ACT_QUEUED;
               end else begin
                  o.act = ACT_DROPPED;
               end
            end else begin
               advance_send_at();
               o.act = ACT_SENT;
            end
         end
         expected_outcomes.push_back(o);
      end else begin
         if (send_at < now) send_at = now;
         while (drained < MAX_DRAIN && held_backlog.size() > 0 && send_at <= now) begin
            o.tag  = held_backlog.pop_front();
            o.act  = ACT_FROM_QUEUE;
            o.last = 1'b0;
            advance_send_at();
            expected_outcomes.push_back(o);
            drained++;
         end
         if (drained > 0) begin
            o = expected_outcomes.pop_back();
            o.last = 1'b1;
            expected_outcomes.push_back(o);
         end
      end
   endfunction

   function automatic void compare_outcome();
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected response tag %h action %0d last %0b",
                     $time, rsp_out_tag, rsp_action, rsp_last_of_run);
      end else begin
         want = expected_outcomes.pop_front();
         compared++;
         if (rsp_out_tag !== want.tag || rsp_action !== want.act ||
             rsp_last_of_run !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("%0t: expected tag %h action %0d last %0b, got tag %h action %0d last %0b",
                        $time, want.tag, want.act, want.last,
                        rsp_out_tag, rsp_action, rsp_last_of_run);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         interval_cfg = RST_SEND_INTERVAL;
         burst_cfg    = RST_BURST_LIMIT;
         send_at      = '0;
         held_backlog.delete();
         expected_outcomes.delete();
      end else begin
         if (rsp_valid) compare_outcome();
         if (req_start && !busy)
            predict_outcomes(req_operation, req_now_seconds, req_message_tag,
                             req_to_server, req_is_tcp_link);
         if (csr_wr_en) begin
            if (csr_index == CSR_SEND_INTERVAL) interval_cfg = csr_wr_data;
            else if (csr_index == CSR_BURST_LIMIT) burst_cfg = csr_wr_data;
         end
      end
      pending <= expected_outcomes.size();
   end

endmodule

@@ verif/flood_control_rate_limiter_test.sv @@
// Top of the flood control rate limiter testbench: clock, reset, limit settings and
// directed plus bursty random request traffic, with the verdict taken from the checker.
// Depends on frl_pkg, flood_control_rate_limiter and frl_outcome_checker.
`timescale 1ns / 1ps

module flood_control_rate_limiter_test;
   import frl_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_start       = 1'b0;
   logic                   req_operation   = OP_MESSAGE;
   logic [TIME_W-1:0]      req_now_seconds = '0;
   logic [TAG_W-1:0]       req_message_tag = '0;
   logic                   req_to_server   = 1'b0;
   logic                   req_is_tcp_link = 1'b0;
   logic                   csr_wr_en       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_SEND_INTERVAL;
   logic [CSR_DATA_W-1:0]  csr_wr_data     = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [TAG_W-1:0]       rsp_out_tag;
   logic [1:0]             rsp_action;
   logic                   rsp_last_of_run;
   int                     mismatches;
   int                     outstanding;
   int                     checked;
   int                     items     = 0;
   int                     settings  = 0;
   int                     quiet     = 0;
   logic [TIME_W-1:0]      wall_time = '0;

   flood_control_rate_limiter DUT (.*);

   frl_outcome_checker outcomes (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_valid || csr_wr_en) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("flood_control_rate_limiter_test failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // leaves req_start high so the next request can follow without a gap
   task automatic issue(input frl_op_type op, input logic [TIME_W-1:0] now,
                        input logic [TAG_W-1:0] tag, input logic srv, input logic tcp);
      req_start       <= 1'b1;
      req_operation   <= op;
      req_now_seconds <= now;
      req_message_tag <= tag;
      req_to_server   <= srv;
      req_is_tcp_link <= tcp;
      @(posedge clock);
      while (busy) @(posedge clock);
      items++;
   endtask

   task automatic rest(input int cycles);
      req_start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // a tick that drains nothing still keeps the block busy briefly
   task automatic settle();
      hold_until_drained();
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] interval,
                             input logic [CSR_DATA_W-1:0] burst);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SEND_INTERVAL;
      csr_wr_data <= interval;
      @(posedge clock);
      csr_index   <= CSR_BURST_LIMIT;
      csr_wr_data <= burst;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings++;
   endtask

   task automatic random_item();
      int                roll;
      logic [TIME_W-1:0] now;
      logic              srv;
      logic              tcp;
      roll = $urandom_range(0, 99);
      if (roll >= 85) wall_time += $urandom_range(4, 300);
      else if (roll >= 60) wall_time += $urandom_range(1, 3);
      now = wall_time;
      if ($urandom_range(0, 99) < 8 && wall_time > 8) now = wall_time - $urandom_range(1, 8);
      srv = 1'b1;
      tcp = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
         srv = 1'($urandom_range(0, 1));
         tcp = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 25)
         issue(OP_TICK, now, 16'($urandom_range(0, 16'hFFFF)), srv, tcp);
      else issue(OP_MESSAGE, now, 16'($urandom_range(0, 16'hFFFF)), srv, tcp);
   endtask

   task automatic random_phase(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && count > 0) begin
            random_item();
            burst--;
            count--;
         end
         if ($urandom_range(0, 19) == 0) hold_until_drained();
         else if ($urandom_range(0, 2) != 0) rest($urandom_range(1, 10));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pass-through, empty tick, then fill the backlog until a drop
      set_limits(8'd1, 8'd0);
      issue(OP_MESSAGE, 32'd0, 16'hFFFF, 1'b0, 1'b1);
      issue(OP_MESSAGE, 32'd0, 16'h0000, 1'b1, 1'b0);
      issue(OP_TICK, 32'd0, 16'h5A5A, 1'b1, 1'b1);
      for (int i = 0; i < FRL_QUEUE_DEPTH + 2; i++)
         issue(OP_MESSAGE, 32'd5, 16'h0100 + 16'(i), 1'b1, 1'b1);
      settle();

      // zero interval: one tick empties the full backlog up to the drain cap
      set_limits(8'd0, 8'd0);
      issue(OP_TICK, 32'd6, 16'h0000, 1'b0, 1'b0);
      settle();

      wall_time = 32'd10;
      set_limits(8'd3, 8'd6);
      random_phase(20);
      settle();
      set_limits(8'd0, 8'd0);
      random_phase(20);
      settle();
      set_limits(8'd255, 8'd255);
      random_phase(20);
      settle();
      wall_time += 32'd20000;
      set_limits(8'd1, 8'd2);
      random_phase(20);
      settle();

      // next-send time saturates at the top of the time range
      set_limits(8'd255, 8'd0);
      issue(OP_MESSAGE, 32'hFFFF_FF80, 16'hC0DE, 1'b1, 1'b1);
      issue(OP_MESSAGE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
      issue(OP_MESSAGE, 32'hFFFF_FF00, 16'h8001, 1'b1, 1'b1);
      issue(OP_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1);
      settle();
      repeat (20) @(posedge clock);

      $display("Run covered %0d requests and %0d checked responses over %0d limit settings,",
               items, checked, settings);
      $display("including pass-through, full backlog drops, capped drains and time saturation.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("flood_control_rate_limiter_test passed");
      end else begin
         $display("flood_control_rate_limiter_test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/frl_pkg.sv
src/frl_ram.sv
src/frl_queue.sv
src/flood_control_rate_limiter.sv
verif/frl_outcome_checker.sv
verif/flood_control_rate_limiter_test.sv
